FILE: rtl/hpgl_pen_path_parser_defines.svh
// Assertion macros for the checker file.
`ifndef HPGL_PEN_PATH_PARSER_DEFINES_SVH
`define HPGL_PEN_PATH_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, held off during reset.
`define HPP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hpp assertion failed");

// Next-cycle implication, sampled on clk_i, held off during reset.
`define HPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hpp assertion failed");

`endif

FILE: rtl/hpp_pkg.sv
package hpp_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned OUT_W           = 32;
  localparam int unsigned QUEUE_DEPTH     = 3;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  localparam logic [15:0] OP_PU = 16'h5055;
  localparam logic [15:0] OP_PD = 16'h5044;
  localparam logic [15:0] OP_IN = 16'h494E;
  localparam logic [15:0] OP_SP = 16'h5350;
  localparam logic [15:0] OP_FS = 16'h4653;
  localparam logic [15:0] OP_VS = 16'h5653;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_PU,
    MODE_PD,
    MODE_SKIP,
    MODE_BAD
  } mode_e;

  typedef enum logic [1:0] {
    PH_EMPTY  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_TRAIL  = 2'd3
  } phase_e;

  typedef struct packed {
    logic              last;
    logic              first;
    logic              kind;
    logic [OUT_W-1:0]  y;
    logic [OUT_W-1:0]  x;
  } res_t;

  function automatic mode_e cmd_mode(input logic [15:0] op, input logic [1:0] nchars);
    mode_e m;
    if (nchars < 2'd2) begin
      m = MODE_NONE;
    end else begin
      unique case (op) inside
        OP_PU:                      m = MODE_PU;
        OP_PD:                      m = MODE_PD;
        OP_IN, OP_SP, OP_FS, OP_VS: m = MODE_SKIP;
        default:                    m = MODE_BAD;
      endcase
    end
    return m;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
  endfunction

endpackage

FILE: rtl/hpgl_pen_path_parser.sv
// HPGL pen path parser. Takes plot text one byte per transaction on the slave
// stream and gives polygon points and error results on the master stream. PU
// moves the pen tail, PD gives the tail and then each complete x,y pair, the
// final point marked by tlast; IN, SP, FS and VS are skipped, and any other
// opcode gives one error result (tuser bit 0 set, data zero) after which the
// block ignores all input until reset. Each byte is decoded in the cycle it
// is taken and its results go into a three-entry output queue, so a byte is
// taken every cycle while the master side keeps up; tready drops while two or
// more results wait in that queue, after the ';' of a PD command that
// completes a pair (two results), and for as long as the master side holds
// off once results have piled up.
module hpgl_pen_path_parser #(
  parameter int unsigned COORD_WIDTH = hpp_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [31:0] point_x, [63:32] point_y
  output logic [1:0]  m_axis_tuser_o,   // [0] kind, [1] first_point
  output logic        m_axis_tlast_o    // last_point
);

  localparam int unsigned Cw   = COORD_WIDTH;
  localparam int unsigned Aw   = COORD_WIDTH + 4;
  localparam int unsigned OutW = hpp_pkg::OUT_W;
  localparam int unsigned QDepth = hpp_pkg::QUEUE_DEPTH;
  localparam logic [Aw-1:0] Lim = Aw'(1) << (COORD_WIDTH - 1);

  logic [15:0]   opcode_q, opcode_d;
  logic [1:0]    nchars_q, nchars_d;
  logic [Aw-1:0] accum_q, accum_d;
  hpp_pkg::phase_e ph_q, ph_d;
  logic          neg_q, neg_d;
  logic          bad_q, bad_d;
  logic [Cw-1:0] prev_q, prev_d;
  logic          fidx_q, fidx_d;
  logic [Cw-1:0] tail_x_q, tail_x_d, tail_y_q, tail_y_d;
  logic [Cw-1:0] held_x_q, held_x_d, held_y_q, held_y_d;
  logic          held_first_q, held_first_d;
  logic          halted_q, halted_d;

  hpp_pkg::res_t slot_q [QDepth];
  hpp_pkg::res_t slot_d [QDepth];
  hpp_pkg::res_t shifted [QDepth];
  logic [1:0]    cnt_q, cnt_d;

  hpp_pkg::res_t res0, res1;
  logic [1:0]    npush;
  logic          accept, pop;
  logic [1:0]    base;
  logic [7:0]    c;
  hpp_pkg::mode_e mode, new_mode;
  logic [Cw-1:0] fval;
  logic          range_ok;
  logic [15:0]   opcode_shift;

  function automatic logic [OutW-1:0] sext(input logic [Cw-1:0] v);
    return OutW'(signed'(v));
  endfunction

  function automatic hpp_pkg::res_t mk_point(input logic [Cw-1:0] x, input logic [Cw-1:0] y,
                                             input logic first, input logic last);
    hpp_pkg::res_t r;
    r.kind  = hpp_pkg::KIND_POINT;
    r.x     = sext(x);
    r.y     = sext(y);
    r.first = first;
    r.last  = last;
    return r;
  endfunction

  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign pop    = m_axis_tvalid_o & m_axis_tready_i;
  assign c      = s_axis_tdata_i;

  assign mode         = hpp_pkg::cmd_mode(opcode_q, nchars_q);
  assign opcode_shift = {opcode_q[7:0], c};
  assign new_mode     = hpp_pkg::cmd_mode(opcode_shift, nchars_q + 2'd1);

  always_comb begin
    range_ok = neg_q ? (accum_q <= Lim) : (accum_q < Lim);
    if (bad_q || (ph_q == hpp_pkg::PH_EMPTY) || (ph_q == hpp_pkg::PH_SIGN) || !range_ok) begin
      fval = '0;
    end else if (neg_q) begin
      fval = Cw'(0) - accum_q[Cw-1:0];
    end else begin
      fval = accum_q[Cw-1:0];
    end
  end

  always_comb begin
    opcode_d     = opcode_q;
    nchars_d     = nchars_q;
    accum_d      = accum_q;
    ph_d         = ph_q;
    neg_d        = neg_q;
    bad_d        = bad_q;
    prev_d       = prev_q;
    fidx_d       = fidx_q;
    tail_x_d     = tail_x_q;
    tail_y_d     = tail_y_q;
    held_x_d     = held_x_q;
    held_y_d     = held_y_q;
    held_first_d = held_first_q;
    halted_d     = halted_q;
    res0         = '0;
    res1         = '0;
    npush        = 2'd0;

    if (accept && !halted_q && (c != hpp_pkg::CH_NL)) begin
      if (c == hpp_pkg::CH_SEMI) begin
        if ((mode == hpp_pkg::MODE_NONE) || (mode == hpp_pkg::MODE_BAD)) begin
          res0.kind = hpp_pkg::KIND_ERROR;
          npush     = 2'd1;
          halted_d  = 1'b1;
        end else begin
          if (mode == hpp_pkg::MODE_PU) begin
            tail_x_d = fidx_q ? prev_q : fval;
            tail_y_d = fval;
          end else if (mode == hpp_pkg::MODE_PD) begin
            if (fidx_q) begin
              res0  = mk_point(held_x_q, held_y_q, held_first_q, 1'b0);
              res1  = mk_point(prev_q, fval, 1'b0, 1'b1);
              npush = 2'd2;
            end else begin
              res0  = mk_point(held_x_q, held_y_q, held_first_q, 1'b1);
              npush = 2'd1;
            end
          end
          opcode_d     = '0;
          nchars_d     = 2'd0;
          accum_d      = '0;
          ph_d         = hpp_pkg::PH_EMPTY;
          neg_d        = 1'b0;
          bad_d        = 1'b0;
          prev_d       = '0;
          fidx_d       = 1'b0;
          held_first_d = 1'b0;
        end
      end else if (nchars_q < 2'd2) begin
        opcode_d = opcode_shift;
        nchars_d = nchars_q + 2'd1;
        if (new_mode == hpp_pkg::MODE_PD) begin
          held_x_d     = tail_x_q;
          held_y_d     = tail_y_q;
          held_first_d = 1'b1;
        end
      end else if ((mode == hpp_pkg::MODE_PU) || (mode == hpp_pkg::MODE_PD)) begin
        if (c == hpp_pkg::CH_COMMA) begin
          accum_d = '0;
          ph_d    = hpp_pkg::PH_EMPTY;
          neg_d   = 1'b0;
          bad_d   = 1'b0;
          if ((mode == hpp_pkg::MODE_PD) && fidx_q) begin
            res0         = mk_point(held_x_q, held_y_q, held_first_q, 1'b0);
            npush        = 2'd1;
            held_x_d     = prev_q;
            held_y_d     = fval;
            held_first_d = 1'b0;
            fidx_d       = 1'b0;
          end else begin
            prev_d = fval;
            fidx_d = 1'b1;
          end
        end else if (hpp_pkg::is_blank(c)) begin
          if (ph_q == hpp_pkg::PH_SIGN) begin
            bad_d = 1'b1;
          end else if (ph_q == hpp_pkg::PH_DIGITS) begin
            ph_d = hpp_pkg::PH_TRAIL;
          end
        end else if ((c == hpp_pkg::CH_PLUS) || (c == hpp_pkg::CH_MINUS)) begin
          if (ph_q == hpp_pkg::PH_EMPTY) begin
            ph_d  = hpp_pkg::PH_SIGN;
            neg_d = (c == hpp_pkg::CH_MINUS);
          end else begin
            bad_d = 1'b1;
          end
        end else if ((c >= hpp_pkg::CH_ZERO) && (c <= hpp_pkg::CH_NINE)) begin
          if (ph_q == hpp_pkg::PH_TRAIL) begin
            bad_d = 1'b1;
          end else begin
            ph_d = hpp_pkg::PH_DIGITS;
            if (accum_q > Lim) begin
              bad_d = 1'b1;
            end else begin
              accum_d = (accum_q << 3) + (accum_q << 1) + Aw'(c[3:0]);
            end
          end
        end else begin
          bad_d = 1'b1;
        end
      end
    end
  end

  // shift the queue down on a pop, append new results behind what remains
  always_comb begin
    shifted[0] = pop ? slot_q[1] : slot_q[0];
    shifted[1] = pop ? slot_q[2] : slot_q[1];
    shifted[2] = slot_q[2];
    base       = cnt_q - {1'b0, pop};
    for (int i = 0; i < QDepth; i++) begin
      if (2'(i) < base) begin
        slot_d[i] = shifted[i];
      end else if ((2'(i) == base) && (npush != 2'd0)) begin
        slot_d[i] = res0;
      end else if ((2'(i) == base + 2'd1) && (npush == 2'd2)) begin
        slot_d[i] = res1;
      end else begin
        slot_d[i] = shifted[i];
      end
    end
    cnt_d = base + npush;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opcode_q     <= '0;
      nchars_q     <= 2'd0;
      accum_q      <= '0;
      ph_q         <= hpp_pkg::PH_EMPTY;
      neg_q        <= 1'b0;
      bad_q        <= 1'b0;
      prev_q       <= '0;
      fidx_q       <= 1'b0;
      tail_x_q     <= '0;
      tail_y_q     <= '0;
      held_x_q     <= '0;
      held_y_q     <= '0;
      held_first_q <= 1'b0;
      halted_q     <= 1'b0;
      cnt_q        <= 2'd0;
    end else begin
      opcode_q     <= opcode_d;
      nchars_q     <= nchars_d;
      accum_q      <= accum_d;
      ph_q         <= ph_d;
      neg_q        <= neg_d;
      bad_q        <= bad_d;
      prev_q       <= prev_d;
      fidx_q       <= fidx_d;
      tail_x_q     <= tail_x_d;
      tail_y_q     <= tail_y_d;
      held_x_q     <= held_x_d;
      held_y_q     <= held_y_d;
      held_first_q <= held_first_d;
      halted_q     <= halted_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  assign s_axis_tready_o = (cnt_q < 2'd2);
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {slot_q[0].y, slot_q[0].x};
  assign m_axis_tuser_o  = {slot_q[0].first, slot_q[0].kind};
  assign m_axis_tlast_o  = slot_q[0].last;

endmodule

FILE: rtl/hpp_checker.sv
`include "hpgl_pen_path_parser_defines.svh"

module hpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // hold a stalled result
  `HPP_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))

  // error result carries no point and no flags
  `HPP_ASSERT_IMPL(a_err_clean, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o == 64'd0 && !m_axis_tlast_o && !m_axis_tuser_o[1])

  // nothing follows a delivered error
  `HPP_ASSERT_NEXT(a_err_final, m_axis_tvalid_o && m_axis_tready_i && m_axis_tuser_o[0], !m_axis_tvalid_o)

  // back-pressure only while results wait
  `HPP_ASSERT_IMPL(a_ready_low, !s_axis_tready_o, m_axis_tvalid_o)

endmodule

bind hpgl_pen_path_parser hpp_checker u_hpp_checker (.*);
